@@ src/dnbs_pkg.sv @@
// Shared types, codes and helpers for the directional nearest box search.
package dnbs_pkg;

  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_CAND  = 1'b1;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam int unsigned SCORE_W = 19;

  typedef struct packed {
    logic               action;
    logic [7:0]         item_id;
    logic signed [15:0] left_edge;
    logic signed [15:0] top_edge;
    logic [14:0]        box_width;
    logic [14:0]        box_height;
    logic [1:0]         direction;
    logic               visible;
    logic               last_candidate;
  } item_t;

  typedef struct packed {
    logic               found;
    logic [7:0]         best_id;
    logic [SCORE_W-1:0] hit_score;
  } result_t;

  // Reference window of the current query.
  typedef struct packed {
    logic signed [16:0] center_x;
    logic signed [16:0] center_y;
    logic [7:0]         identity;
    logic [1:0]         side;
  } ref_state_t;

  // edge + size/2, truncated
  function automatic logic signed [16:0] center_of(input logic signed [15:0] edge_pos,
                                                   input logic [14:0] size);
    logic signed [16:0] ext_edge;
    logic signed [16:0] half;
    ext_edge = {edge_pos[15], edge_pos};
    half     = $signed({3'b000, size[14:1]});
    return ext_edge + half;
  endfunction

endpackage

@@ src/dnbs_score.sv @@
// Scores one candidate box against the reference window.
module dnbs_score (
  input  dnbs_pkg::ref_state_t             ref_st,
  input  dnbs_pkg::item_t                  cand,
  output logic                             qualify,
  output logic [dnbs_pkg::SCORE_W-1:0]     score
);

  logic signed [16:0] cx;
  logic signed [16:0] cy;
  logic signed [17:0] dx;
  logic signed [17:0] dy;
  logic [17:0]        adx;
  logic [17:0]        ady;
  logic [17:0]        primary;
  logic [17:0]        secondary;
  logic               on_side;

  always_comb begin
    cx  = dnbs_pkg::center_of(cand.left_edge, cand.box_width);
    cy  = dnbs_pkg::center_of(cand.top_edge, cand.box_height);
    dx  = {cx[16], cx} - {ref_st.center_x[16], ref_st.center_x};
    dy  = {cy[16], cy} - {ref_st.center_y[16], ref_st.center_y};
    adx = dx[17] ? 18'(-dx) : 18'(dx);
    ady = dy[17] ? 18'(-dy) : 18'(dy);

    case (ref_st.side)
      dnbs_pkg::DIR_LEFT: begin
        on_side   = dx[17];
        primary   = adx;
        secondary = ady;
      end
      dnbs_pkg::DIR_RIGHT: begin
        on_side   = !dx[17] && (dx != 18'sd0);
        primary   = adx;
        secondary = ady;
      end
      dnbs_pkg::DIR_UP: begin
        on_side   = dy[17];
        primary   = ady;
        secondary = adx;
      end
      default: begin
        on_side   = !dy[17] && (dy != 18'sd0);
        primary   = ady;
        secondary = adx;
      end
    endcase

    // magnitudes stay below 2^17, so the sum fits without wrap
    score   = {1'b0, primary} + {secondary, 1'b0};
    qualify = on_side && cand.visible && (cand.item_id != ref_st.identity);
  end

endmodule

@@ src/dnbs_best.sv @@
// Query state: reference window and running best candidate.
module dnbs_best (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  dnbs_pkg::item_t      item,
  output logic                 emit,
  output dnbs_pkg::result_t    result
);

  dnbs_pkg::ref_state_t          ref_st;
  dnbs_pkg::ref_state_t          ref_st_next;
  logic                          have_best;
  logic                          have_best_next;
  logic [7:0]                    winner_id;
  logic [7:0]                    winner_id_next;
  logic [dnbs_pkg::SCORE_W-1:0]  winner_score;
  logic [dnbs_pkg::SCORE_W-1:0]  winner_score_next;
  logic                          qualify;
  logic [dnbs_pkg::SCORE_W-1:0]  score;

  dnbs_score u_score (
    .ref_st  (ref_st),
    .cand    (item),
    .qualify (qualify),
    .score   (score)
  );

  always_comb begin
    ref_st_next       = ref_st;
    have_best_next    = have_best;
    winner_id_next    = winner_id;
    winner_score_next = winner_score;
    if (item.action == dnbs_pkg::ACT_BEGIN) begin
      ref_st_next.center_x = dnbs_pkg::center_of(item.left_edge, item.box_width);
      ref_st_next.center_y = dnbs_pkg::center_of(item.top_edge, item.box_height);
      ref_st_next.identity = item.item_id;
      ref_st_next.side     = item.direction;
      have_best_next       = 1'b0;
      winner_id_next       = '0;
      winner_score_next    = '0;
    end else if (qualify && (!have_best || score < winner_score)) begin
      // strict compare: earliest candidate keeps a tie
      have_best_next    = 1'b1;
      winner_id_next    = item.item_id;
      winner_score_next = score;
    end
  end

  // winner fields are zero whenever nothing has qualified
  assign emit              = (item.action == dnbs_pkg::ACT_CAND) && item.last_candidate;
  assign result.found      = have_best_next;
  assign result.best_id    = winner_id_next;
  assign result.hit_score  = winner_score_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_st       <= '0;
      have_best    <= 1'b0;
      winner_id    <= '0;
      winner_score <= '0;
    end else if (step) begin
      ref_st       <= ref_st_next;
      have_best    <= have_best_next;
      winner_id    <= winner_id_next;
      winner_score <= winner_score_next;
    end
  end

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    !have_best |-> (winner_id == 8'd0) && (winner_score == '0))
    else $error("winner fields nonzero with no best");

  a_begin_clears: assert property (@(posedge clk) disable iff (rst)
    step && (item.action == dnbs_pkg::ACT_BEGIN) |=> !have_best)
    else $error("begin did not clear best");

  a_score_monotonic: assert property (@(posedge clk) disable iff (rst)
    step && (item.action == dnbs_pkg::ACT_CAND) && have_best
      |=> have_best && (winner_score <= $past(winner_score)))
    else $error("best score grew within a query");

endmodule

@@ src/directional_nearest_box_search_top.sv @@
// Directional nearest box search: input register, scoring/update, result register.
// A result is registered as the last candidate advances out of the input register.
// One item per cycle unless the result stalls; scoring and update are combinational.
// A stalled result holds only emitting items; other items keep flowing past it.
// Reset (rst, synchronous): clears the query state, best choice and both valid flags.
module directional_nearest_box_search_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  dnbs_pkg::item_t      item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output dnbs_pkg::result_t    result
);

  logic                 stage_valid;
  dnbs_pkg::item_t      stage_item;
  logic                 stage_emit;
  logic                 advance;
  dnbs_pkg::result_t    next_result;

  dnbs_best u_best (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (stage_item),
    .emit   (stage_emit),
    .result (next_result)
  );

  assign advance    = stage_valid && (!stage_emit || !result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && stage_emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_emit) begin
      result <= next_result;
    end
  end

endmodule

@@ tb/tb_directional_nearest_box_search_top.sv @@
// Testbench for the directional nearest box search: directed and random queries checked against a predictor.
module tb_directional_nearest_box_search_top;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  dnbs_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  dnbs_pkg::result_t result;

  directional_nearest_box_search_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dnbs_pkg::item_t   boxes_q[$];
  dnbs_pkg::result_t answers_q[$];

  // predicted query state, reset values
  int         anchor_x = 0;
  int         anchor_y = 0;
  logic [7:0] anchor_id = '0;
  logic [1:0] search_dir = dnbs_pkg::DIR_LEFT;
  bit         lead_valid = 1'b0;
  logic [7:0] lead_id = '0;
  int         lead_score = 0;

  int n_items = 0;
  int n_sent = 0;
  int n_queries = 0;
  int n_checked = 0;
  int n_hits = 0;
  int n_bad = 0;
  int feed_gap = 0;
  int drain_hold = 0;
  bit feed_steady = 1'b0;
  bit drain_steady = 1'b0;

  task automatic search_step(input dnbs_pkg::item_t it);
    int                cx, cy, dx, dy, ax, ay, along, across, score;
    bit                on_side;
    dnbs_pkg::result_t r;
    cx = $signed(it.left_edge) + int'(it.box_width >> 1);
    cy = $signed(it.top_edge) + int'(it.box_height >> 1);
    if (it.action == dnbs_pkg::ACT_BEGIN) begin
      anchor_x   = cx;
      anchor_y   = cy;
      anchor_id  = it.item_id;
      search_dir = it.direction;
      lead_valid = 1'b0;
      lead_id    = '0;
      lead_score = 0;
      n_queries++;
      return;
    end
    if (it.item_id != anchor_id && it.visible) begin
      dx = cx - anchor_x;
      dy = cy - anchor_y;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      case (search_dir)
        dnbs_pkg::DIR_LEFT:  begin on_side = dx < 0; along = ax; across = ay; end
        dnbs_pkg::DIR_RIGHT: begin on_side = dx > 0; along = ax; across = ay; end
        dnbs_pkg::DIR_UP:    begin on_side = dy < 0; along = ay; across = ax; end
        default:             begin on_side = dy > 0; along = ay; across = ax; end
      endcase
      score = (along + 2 * across) & 'h7FFFF;
      // strict compare: the earliest candidate keeps a tie
      if (on_side && (!lead_valid || score < lead_score)) begin
        lead_valid = 1'b1;
        lead_id    = it.item_id;
        lead_score = score;
      end
    end
    if (it.last_candidate) begin
      r.found     = lead_valid;
      r.best_id   = lead_valid ? lead_id : 8'd0;
      r.hit_score = lead_valid ? lead_score[dnbs_pkg::SCORE_W-1:0] : '0;
      answers_q.push_back(r);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [14:0] pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 15'd0;
    if (r < 3) return 15'($urandom_range(1, 32767));
    return 15'($urandom_range(1, 300));
  endfunction

  function automatic dnbs_pkg::item_t make_box(logic act, logic [7:0] id, int l, int t,
                                               int w, int h, logic [1:0] dir, logic vis,
                                               logic last);
    dnbs_pkg::item_t it;
    it.action         = act;
    it.item_id        = id;
    it.left_edge      = 16'(l);
    it.top_edge       = 16'(t);
    it.box_width      = 15'(w);
    it.box_height     = 15'(h);
    it.direction      = dir;
    it.visible        = vis;
    it.last_candidate = last;
    return it;
  endfunction

  // mostly near the reference so candidates compete; some anywhere in layout space
  function automatic dnbs_pkg::item_t rand_box(int x0, int y0);
    dnbs_pkg::item_t it;
    it = '0;
    it.item_id = 8'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      it.left_edge = 16'($urandom);
      it.top_edge  = 16'($urandom);
    end else begin
      it.left_edge = 16'(x0 + int'($urandom_range(0, 1200)) - 600);
      it.top_edge  = 16'(y0 + int'($urandom_range(0, 1200)) - 600);
    end
    it.box_width  = pick_size();
    it.box_height = pick_size();
    it.direction  = 2'($urandom);
    it.visible    = ($urandom_range(0, 6) != 0);
    return it;
  endfunction

  task automatic queue_query();
    dnbs_pkg::item_t it, prev;
    int              x0, y0, ncand;
    logic [7:0]      rid;
    x0 = int'($urandom_range(0, 4000)) - 2000;
    y0 = int'($urandom_range(0, 4000)) - 2000;
    it = rand_box(x0, y0);
    it.action = dnbs_pkg::ACT_BEGIN;
    it.last_candidate = ($urandom_range(0, 9) == 0);
    rid = it.item_id;
    boxes_q.push_back(it);
    ncand = $urandom_range(1, 10);
    prev = it;
    for (int i = 0; i < ncand; i++) begin
      it = rand_box(x0, y0);
      it.action = dnbs_pkg::ACT_CAND;
      if ($urandom_range(0, 7) == 0) it.item_id = rid;
      if (i > 0 && $urandom_range(0, 7) == 0) begin
        // same geometry, new id: tie on score
        it.left_edge  = prev.left_edge;
        it.top_edge   = prev.top_edge;
        it.box_width  = prev.box_width;
        it.box_height = prev.box_height;
      end
      if (i == ncand - 1) it.last_candidate = ($urandom_range(0, 19) != 0);
      else it.last_candidate = ($urandom_range(0, 24) == 0);
      boxes_q.push_back(it);
      prev = it;
    end
  endtask

  // driver: next item loads once the current one transfers
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        search_step(item);
        n_sent++;
      end
      if (!item_valid || item_ready) begin
        if (feed_gap > 0) begin
          feed_gap--;
          item_valid <= 1'b0;
        end else if (boxes_q.size() != 0) begin
          item <= boxes_q.pop_front();
          item_valid <= 1'b1;
          if ($urandom_range(0, 149) == 0) feed_steady = !feed_steady;
          feed_gap = feed_steady ? 0 : pick_gap();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side backpressure
  always @(posedge clk) begin
    dnbs_pkg::result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (answers_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: result with nothing expected: found=%0b id=%0d score=%0d",
                     $realtime, result.found, result.best_id, result.hit_score);
        end else begin
          want = answers_q.pop_front();
          n_checked++;
          if (want.found) n_hits++;
          if (result.found !== want.found || result.best_id !== want.best_id ||
              result.hit_score !== want.hit_score) begin
            n_bad++;
            if (n_bad <= 10)
              $display({"%0t: mismatch: expected found=%0b id=%0d score=%0d, ",
                        "got found=%0b id=%0d score=%0d"},
                       $realtime, want.found, want.best_id, want.hit_score,
                       result.found, result.best_id, result.hit_score);
          end
        end
      end
      if (drain_hold > 0) begin
        drain_hold--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if ($urandom_range(0, 199) == 0) drain_steady = !drain_steady;
        if (!drain_steady && $urandom_range(0, 3) == 0) drain_hold = pick_gap();
      end
    end
  end

  initial begin
    // candidates before any begin see the reset reference: centre (0,0), id 0, left
    boxes_q.push_back(make_box(dnbs_pkg::ACT_CAND, 8'd0, 0, 0, 2, 2,
                               dnbs_pkg::DIR_LEFT, 1'b1, 1'b1));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_CAND, 8'd5, -100, 0, 2, 2,
                               dnbs_pkg::DIR_LEFT, 1'b1, 1'b1));
    // begin marked last emits nothing
    boxes_q.push_back(make_box(dnbs_pkg::ACT_BEGIN, 8'd10, 0, 0, 100, 100,
                               dnbs_pkg::DIR_RIGHT, 1'b1, 1'b1));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_CAND, 8'd10, 300, 0, 100, 100,
                               dnbs_pkg::DIR_RIGHT, 1'b1, 1'b0));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_CAND, 8'd11, 150, 0, 100, 100,
                               dnbs_pkg::DIR_RIGHT, 1'b0, 1'b0));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_CAND, 8'd12, 200, 0, 100, 100,
                               dnbs_pkg::DIR_RIGHT, 1'b1, 1'b0));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_CAND, 8'd13, 200, 0, 100, 100,
                               dnbs_pkg::DIR_RIGHT, 1'b1, 1'b0));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_CAND, 8'd14, 0, 0, 100, 100,
                               dnbs_pkg::DIR_RIGHT, 1'b1, 1'b1));
    // query keeps running after a last candidate
    boxes_q.push_back(make_box(dnbs_pkg::ACT_CAND, 8'd15, 100, 0, 100, 100,
                               dnbs_pkg::DIR_RIGHT, 1'b1, 1'b1));
    // coordinate and size extremes, zero size
    boxes_q.push_back(make_box(dnbs_pkg::ACT_BEGIN, 8'd1, 32767, 32767, 32767, 32767,
                               dnbs_pkg::DIR_LEFT, 1'b0, 1'b0));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_CAND, 8'd2, -32768, -32768, 0, 0,
                               dnbs_pkg::DIR_DOWN, 1'b1, 1'b1));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_BEGIN, 8'd255, -32768, -32768, 1, 1,
                               dnbs_pkg::DIR_UP, 1'b1, 1'b0));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_CAND, 8'd3, -32768, -32768, 32767, 1,
                               dnbs_pkg::DIR_UP, 1'b1, 1'b1));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_BEGIN, 8'd20, 0, 0, 10, 10,
                               dnbs_pkg::DIR_UP, 1'b0, 1'b0));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_CAND, 8'd21, 0, -50, 10, 10,
                               dnbs_pkg::DIR_LEFT, 1'b1, 1'b0));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_CAND, 8'd22, 30, -60, 10, 10,
                               dnbs_pkg::DIR_RIGHT, 1'b1, 1'b0));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_CAND, 8'd23, 0, 50, 10, 10,
                               dnbs_pkg::DIR_UP, 1'b1, 1'b1));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_BEGIN, 8'd30, 0, 0, 10, 10,
                               dnbs_pkg::DIR_DOWN, 1'b0, 1'b0));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_CAND, 8'd31, -20, 40, 10, 10,
                               dnbs_pkg::DIR_DOWN, 1'b1, 1'b0));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_CAND, 8'd32, 0, 100, 10, 10,
                               dnbs_pkg::DIR_DOWN, 1'b1, 1'b1));
    boxes_q.push_back(make_box(dnbs_pkg::ACT_CAND, 8'd255, -20, 40, 10, 10,
                               dnbs_pkg::DIR_DOWN, 1'b0, 1'b1));
    while (boxes_q.size() < 1020) queue_query();
    n_items = boxes_q.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (n_sent != n_items) @(posedge clk);
    while (answers_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d items in %0d queries; checked %0d search results, %0d with a hit.",
             n_items, n_queries, n_checked, n_hits);
    $display("Mismatches and stray results: %0d", n_bad);
    if (n_bad == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d of %0d items sent, %0d results outstanding",
             n_sent, n_items, answers_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ directional_nearest_box_search_top.f @@
src/dnbs_pkg.sv
src/dnbs_score.sv
src/dnbs_best.sv
src/directional_nearest_box_search_top.sv
tb/tb_directional_nearest_box_search_top.sv
